FILE: hdl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types, codes and helpers for the form field decoder.
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int unsigned MaxResults = 3;

    localparam logic [7:0] CHAR_EQ   = 8'h3D;
    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_PCT  = 8'h25;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UZ   = 8'h5A;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_SP   = 8'h20;

    typedef enum logic [1:0] {
        PH_KEY    = 2'd0,
        PH_VALUE  = 2'd1,
        PH_ESC_HI = 2'd2,
        PH_ESC_LO = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_KEY     = 3'd0,
        KIND_VALUE   = 3'd1,
        KIND_FIELD   = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_DROPPED = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // unchecked hex digit map, modulo 256
    function automatic logic [7:0] hex_map(input logic [7:0] c);
        logic [7:0] r;
        if (c <= CHAR_9)
        begin
            r = c - CHAR_0;
        end
        else if (c <= CHAR_UZ)
        begin
            r = c - CHAR_UA + 8'd10;
        end
        else
        begin
            r = c - CHAR_LA + 8'd10;
        end
        return r;
    endfunction

endpackage

FILE: hdl/form_field_decoder_unit.sv
// ----------------------------------------------------------------------------
// form_field_decoder_unit
// Streaming decoder for a form-urlencoded body into key and value words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one body byte per word in s_tdata, s_tlast on the final
//   byte. Master stream: one result word per transfer; m_tuser is the kind
//   (key byte, value byte, field done, input done, input done key dropped),
//   m_tdata the raw or decoded byte (zero for marker kinds), m_tlast marks
//   the last result word caused by one body byte.
//   A taken byte is decoded and loaded once the result register is free,
//   and its first result word is offered from then on. With m_tready high
//   the input takes one byte per cycle while each byte yields at most one
//   word; a byte yielding more holds the input until its last word is taken.
//   The result register drains one word per cycle and reloads as it empties.
//   Reset: decoder returns to the key phase, both stages empty.
//   Stall: with m_tready low the result register holds, the input register
//   fills and then s_tready drops.
// ----------------------------------------------------------------------------
module form_field_decoder_unit
    import ffd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] out_kind
    output logic        m_tlast
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          advance;
    logic          free;
    result_t [2:0] res;
    logic [1:0]    res_count;
    result_t       head;

    assign advance  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ffd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res       (res),
        .res_count (res_count)
    );

    ffd_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_res   (res),
        .load_count (res_count),
        .free       (free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head       (head)
    );

    assign m_tdata = head.data;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

FILE: hdl/ffd_step.sv
// ----------------------------------------------------------------------------
// ffd_step
// Phase state and combinational decode of one body byte into up to three
// result words.
// ----------------------------------------------------------------------------
module ffd_step
    import ffd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output result_t [2:0]     res,
    output logic [1:0]        res_count
);

    phase_t     phase_reg, phase_next;
    logic [3:0] nibble_reg, nibble_next;

    always_comb
    begin
        phase_t     ph_mid;
        logic       has0;
        result_t    r0;
        result_t    t0;
        result_t    t1;
        logic [1:0] n;
        logic [7:0] hx;

        hx          = hex_map(in_byte);
        ph_mid      = phase_reg;
        nibble_next = nibble_reg;
        has0        = 1'b0;
        r0          = '{kind: KIND_KEY, data: 8'h00, last: 1'b0};

        unique case (phase_reg)
            PH_KEY:
            begin
                if (in_byte == CHAR_EQ)
                begin
                    ph_mid = PH_VALUE;
                end
                else
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_KEY;
                    r0.data = in_byte;
                end
            end
            PH_VALUE:
            begin
                if (in_byte == CHAR_AMP)
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_FIELD;
                    ph_mid  = PH_KEY;
                end
                else if (in_byte == CHAR_PLUS)
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_VALUE;
                    r0.data = CHAR_SP;
                end
                else if (in_byte == CHAR_PCT)
                begin
                    ph_mid = PH_ESC_HI;
                end
                else
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_VALUE;
                    r0.data = in_byte;
                end
            end
            PH_ESC_HI:
            begin
                if (in_byte == CHAR_AMP)
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_FIELD;
                    ph_mid  = PH_KEY;
                end
                else
                begin
                    nibble_next = hx[3:0];
                    ph_mid      = PH_ESC_LO;
                end
            end
            PH_ESC_LO:
            begin
                if (in_byte == CHAR_AMP)
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_FIELD;
                    ph_mid  = PH_KEY;
                end
                else
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_VALUE;
                    r0.data = {nibble_reg, 4'h0} | hx;
                    ph_mid  = PH_VALUE;
                end
            end
        endcase

        // end-of-body tail
        t0 = '{kind: KIND_DROPPED, data: 8'h00, last: 1'b1};
        t1 = '{kind: KIND_DONE,    data: 8'h00, last: 1'b1};
        n  = {1'b0, has0};
        phase_next = ph_mid;
        res = '0;

        if (in_last)
        begin
            phase_next  = PH_KEY;
            nibble_next = 4'h0;
            if (ph_mid == PH_KEY)
            begin
                t0 = '{kind: KIND_DROPPED, data: 8'h00, last: 1'b1};
                if (has0)
                begin
                    res[0] = r0;
                    res[1] = t0;
                    n      = 2'd2;
                end
                else
                begin
                    res[0] = t0;
                    n      = 2'd1;
                end
            end
            else
            begin
                t0 = '{kind: KIND_FIELD, data: 8'h00, last: 1'b0};
                if (has0)
                begin
                    res[0] = r0;
                    res[1] = t0;
                    res[2] = t1;
                    n      = 2'd3;
                end
                else
                begin
                    res[0] = t0;
                    res[1] = t1;
                    n      = 2'd2;
                end
            end
        end
        else if (has0)
        begin
            r0.last = 1'b1;
            res[0]  = r0;
        end
        res_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            nibble_reg <= 4'h0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
        end
    end

`ifndef SYNTHESIS
    a_last_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last |=> phase_reg == PH_KEY && nibble_reg == 4'h0)
        else $error("state not cleared after final byte");

    a_last_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last |-> res_count != 2'd0)
        else $error("final byte gave no results");

    a_set_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_count != 2'd0 |-> res[res_count - 2'd1].last)
        else $error("result set not terminated by last");
`endif

endmodule

FILE: hdl/ffd_result_queue.sv
// ----------------------------------------------------------------------------
// ffd_result_queue
// Result register holding one step's set of up to three words, drained one
// word per cycle onto the master stream while m_tready is high.
// ----------------------------------------------------------------------------
module ffd_result_queue
    import ffd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  result_t [2:0]     load_res,
    input  logic [1:0]        load_count,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output result_t           head
);

    result_t [2:0] q_reg, q_next;
    logic [1:0]    count_reg, count_next;
    logic          pop;

    assign pop      = (count_reg != 2'd0) && m_tready;
    assign free     = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);
    assign m_tvalid = (count_reg != 2'd0);
    assign head     = q_reg[0];

    always_comb
    begin
        q_next     = q_reg;
        count_next = count_reg;
        if (load)
        begin
            q_next     = load_res;
            count_next = load_count;
        end
        else if (pop)
        begin
            q_next[0]  = q_reg[1];
            q_next[1]  = q_reg[2];
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

`ifndef SYNTHESIS
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 |-> q_reg[0].last)
        else $error("final pending word lacks last");

    a_multi_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= 2'd2 |-> !q_reg[0].last)
        else $error("last set before end of result set");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> count_reg == 2'd0 || (count_reg == 2'd1 && pop))
        else $error("result set overwritten");
`endif

endmodule

FILE: tb/ffd_result_checker.sv
// ----------------------------------------------------------------------------
// ffd_result_checker
// Watches both streams of the form field decoder, predicts the result words
// of each accepted body byte and compares every result word in order.
// ----------------------------------------------------------------------------
module ffd_result_checker
    import ffd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic [2:0]  m_tuser,   // [2:0] out_kind
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t     dec_phase;
    logic [3:0] esc_high;
    result_t    expected_words [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] base;
        logic [7:0] bias;
        bias = 8'd10;
        if (c <= CHAR_9)
        begin
            base = CHAR_0;
            bias = 8'd0;
        end
        else if (c <= CHAR_UZ)
        begin
            base = CHAR_UA;
        end
        else
        begin
            base = CHAR_LA;
        end
        return c + bias - base;
    endfunction

    function automatic result_t make_word(input kind_t k, input logic [7:0] d);
        result_t w;
        w.kind = k;
        w.data = d;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic void decode_body_byte(input logic [7:0] b, input logic fin);
        result_t    words [3];
        int         n;
        logic [7:0] dv;
        n = 0;
        case (dec_phase)
            PH_KEY:
            begin
                if (b == CHAR_EQ)
                begin
                    dec_phase = PH_VALUE;
                end
                else
                begin
                    words[n] = make_word(KIND_KEY, b);
                    n++;
                end
            end
            PH_VALUE:
            begin
                if (b == CHAR_AMP)
                begin
                    words[n] = make_word(KIND_FIELD, 8'h00);
                    n++;
                    dec_phase = PH_KEY;
                end
                else if (b == CHAR_PLUS)
                begin
                    words[n] = make_word(KIND_VALUE, CHAR_SP);
                    n++;
                end
                else if (b == CHAR_PCT)
                begin
                    dec_phase = PH_ESC_HI;
                end
                else
                begin
                    words[n] = make_word(KIND_VALUE, b);
                    n++;
                end
            end
            PH_ESC_HI:
            begin
                if (b == CHAR_AMP)
                begin
                    words[n] = make_word(KIND_FIELD, 8'h00);
                    n++;
                    dec_phase = PH_KEY;
                end
                else
                begin
                    dv        = digit_value(b);
                    esc_high  = dv[3:0];
                    dec_phase = PH_ESC_LO;
                end
            end
            default:
            begin
                if (b == CHAR_AMP)
                begin
                    words[n] = make_word(KIND_FIELD, 8'h00);
                    n++;
                    dec_phase = PH_KEY;
                end
                else
                begin
                    words[n] = make_word(KIND_VALUE, {esc_high, 4'h0} | digit_value(b));
                    n++;
                    dec_phase = PH_VALUE;
                end
            end
        endcase

        if (fin)
        begin
            if (dec_phase == PH_KEY)
            begin
                words[n] = make_word(KIND_DROPPED, 8'h00);
                n++;
            end
            else
            begin
                words[n] = make_word(KIND_FIELD, 8'h00);
                n++;
                words[n] = make_word(KIND_DONE, 8'h00);
                n++;
            end
            dec_phase = PH_KEY;
            esc_high  = 4'h0;
        end

        for (int i = 0; i < n; i++)
        begin
            words[i].last = (i == n - 1);
            expected_words.push_back(words[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_phase = PH_KEY;
            esc_high  = 4'h0;
            expected_words.delete();
        end
        else
        begin
            result_t want;
            if (s_tvalid && s_tready)
            begin
                decode_body_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word", 8'h00, m_tdata);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tuser != want.kind)
                    begin
                        report_mismatch("kind", {5'b0, want.kind}, {5'b0, m_tuser});
                    end
                    if (m_tdata != want.data)
                    begin
                        report_mismatch("byte", want.data, m_tdata);
                    end
                    if (m_tlast != want.last)
                    begin
                        report_mismatch("last flag", {7'b0, want.last}, {7'b0, m_tlast});
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

FILE: tb/tb_form_field_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_form_field_decoder_unit
// Drives form bodies into the decoder: a directed set of separator, escape
// and end-of-body cases, then random well-formed, broken and noise bodies,
// with random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_form_field_decoder_unit
    import ffd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems = 450;
    localparam int CycleLimit  = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic [2:0]  m_tuser;   // [2:0] out_kind
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          random_count;
    logic        steady;
    logic [7:0]  body_bytes [$];

    form_field_decoder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ffd_result_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("form_field_decoder_unit verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] b, input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
        begin
            return CHAR_0 + 8'(k);
        end
        else if (k < 16)
        begin
            return CHAR_UA + 8'(k - 10);
        end
        return CHAR_LA + 8'(k - 16);
    endfunction

    function automatic logic [7:0] key_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CHAR_EQ);
        return b;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CHAR_AMP || b == CHAR_PLUS || b == CHAR_PCT);
        return b;
    endfunction

    // styles: 0-2 noise, 3 missing '=', 4-8 broken tails, rest well-formed
    task automatic build_body();
        int style;
        int nf;
        int sel;
        style = $urandom_range(0, 19);
        body_bytes.delete();
        if (style < 3)
        begin
            repeat ($urandom_range(1, 8)) body_bytes.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf; f++)
            begin
                if (f > 0)
                begin
                    body_bytes.push_back(CHAR_AMP);
                end
                repeat ($urandom_range(0, 4)) body_bytes.push_back(key_char());
                if (!(style == 3 && f == nf - 1))
                begin
                    body_bytes.push_back(CHAR_EQ);
                end
                repeat ($urandom_range(0, 5))
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6)
                    begin
                        body_bytes.push_back(value_char());
                    end
                    else if (sel == 6)
                    begin
                        body_bytes.push_back(CHAR_PLUS);
                    end
                    else if (sel < 9)
                    begin
                        body_bytes.push_back(CHAR_PCT);
                        body_bytes.push_back(hex_char());
                        body_bytes.push_back(hex_char());
                    end
                    else
                    begin
                        // escape with arbitrary digit bytes
                        body_bytes.push_back(CHAR_PCT);
                        body_bytes.push_back(8'($urandom_range(1, 255)));
                        body_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                end
            end
            case (style)
                4: body_bytes.push_back(CHAR_PCT);
                5:
                begin
                    body_bytes.push_back(CHAR_PCT);
                    body_bytes.push_back(hex_char());
                end
                6:
                begin
                    body_bytes.push_back(CHAR_PCT);
                    body_bytes.push_back(hex_char());
                    body_bytes.push_back(CHAR_AMP);
                end
                7: body_bytes.push_back(CHAR_AMP);
                8:
                begin
                    body_bytes.push_back(CHAR_PCT);
                    body_bytes.push_back(CHAR_AMP);
                end
                default: ;
            endcase
        end
        if (body_bytes.size() == 0)
        begin
            body_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        steady   = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // key with '&' inside, '+', upper and lower escapes, non-hex escape
        send_word(8'h6B, 1'b0);
        send_word(CHAR_AMP, 1'b0);
        send_word(CHAR_EQ, 1'b0);
        send_word(CHAR_PLUS, 1'b0);
        send_word(CHAR_PCT, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(CHAR_PCT, 1'b0);
        send_word(8'h36, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(CHAR_PCT, 1'b0);
        send_word(8'h47, 1'b0);
        send_word(8'h21, 1'b0);
        send_word(8'hFF, 1'b0);
        // escape cut short by '&'
        send_word(CHAR_PCT, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(CHAR_AMP, 1'b0);
        // body ends inside a key
        send_word(8'h01, 1'b1);
        // body ends on a bare escape
        send_word(CHAR_EQ, 1'b0);
        send_word(CHAR_PCT, 1'b1);
        // trailing '&' leaves an empty key
        send_word(CHAR_EQ, 1'b0);
        send_word(CHAR_AMP, 1'b1);
        // full escape on the final byte: three words
        send_word(CHAR_EQ, 1'b0);
        send_word(CHAR_PCT, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h31, 1'b1);

        drain_results();

        random_count = 0;
        while (random_count < RandomItems)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                drain_results();
            end
            build_body();
            for (int i = 0; i < body_bytes.size(); i++)
            begin
                send_word(body_bytes[i], i == body_bytes.size() - 1);
            end
            random_count += body_bytes.size();
        end

        steady = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("form_field_decoder_unit verification clean");
        end
        else
        begin
            $display("form_field_decoder_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/ffd_pkg.sv
hdl/ffd_step.sv
hdl/ffd_result_queue.sv
hdl/form_field_decoder_unit.sv
tb/ffd_result_checker.sv
tb/tb_form_field_decoder_unit.sv
